FILE: rtl/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks.
// No dependencies; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is low.
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled while the active-low reset is low.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

FILE: rtl/adf_pkg.sv
// Package for the ASCII decimal to fixed-point parser: character codes,
// fraction digit limit, format codes and the per-digit fraction term tables. No dependencies.
`timescale 1ns / 1ps

package adf_pkg;

    localparam int unsigned ADF_MAX_FRAC_DIGITS = 5;

    localparam logic [7:0] ADF_CH_MINUS  = 8'h2D;
    localparam logic [7:0] ADF_CH_PERIOD = 8'h2E;
    localparam logic [7:0] ADF_CH_ZERO   = 8'h30;
    localparam logic [7:0] ADF_CH_NINE   = 8'h39;

    localparam logic ADF_FMT_16_16 = 1'b0;
    localparam logic ADF_FMT_24_8  = 1'b1;

    typedef logic [16:0] t_frac;
    typedef t_frac t_frac_row [10];

    // floor((d << 16) / 10^(k+1)), row k, column d
    localparam t_frac_row FRAC16_TAB [5] = '{
        '{17'd0, 17'd6553, 17'd13107, 17'd19660, 17'd26214,
          17'd32768, 17'd39321, 17'd45875, 17'd52428, 17'd58982},
        '{17'd0, 17'd655, 17'd1310, 17'd1966, 17'd2621,
          17'd3276, 17'd3932, 17'd4587, 17'd5242, 17'd5898},
        '{17'd0, 17'd65, 17'd131, 17'd196, 17'd262,
          17'd327, 17'd393, 17'd458, 17'd524, 17'd589},
        '{17'd0, 17'd6, 17'd13, 17'd19, 17'd26,
          17'd32, 17'd39, 17'd45, 17'd52, 17'd58},
        '{17'd0, 17'd0, 17'd1, 17'd1, 17'd2,
          17'd3, 17'd3, 17'd4, 17'd5, 17'd5}
    };

    // floor((d << 8) / 10^(k+1)), row k, column d
    localparam t_frac_row FRAC8_TAB [5] = '{
        '{17'd0, 17'd25, 17'd51, 17'd76, 17'd102,
          17'd128, 17'd153, 17'd179, 17'd204, 17'd230},
        '{17'd0, 17'd2, 17'd5, 17'd7, 17'd10,
          17'd12, 17'd15, 17'd17, 17'd20, 17'd23},
        '{17'd0, 17'd0, 17'd0, 17'd0, 17'd1,
          17'd1, 17'd1, 17'd1, 17'd2, 17'd2},
        '{17'd0, 17'd0, 17'd0, 17'd0, 17'd0,
          17'd0, 17'd0, 17'd0, 17'd0, 17'd0},
        '{17'd0, 17'd0, 17'd0, 17'd0, 17'd0,
          17'd0, 17'd0, 17'd0, 17'd0, 17'd0}
    };

    // Term added by fractional digit d at position k (k = 0 is the tenths digit).
    function automatic t_frac adf_frac_term(input logic fmt, input logic [2:0] k,
                                            input logic [3:0] d);
        t_frac term;
        term = '0;
        if ((k < 3'd5) && (d < 4'd10)) begin
            if (fmt == ADF_FMT_24_8) begin
                term = FRAC8_TAB[k][d];
            end else begin
                term = FRAC16_TAB[k][d];
            end
        end
        return term;
    endfunction

endpackage

FILE: rtl/adf_in_if.sv
// Character stream channel: valid/ready handshake with one character
// and its end-of-string mark. No dependencies.
`timescale 1ns / 1ps

interface adf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last_char;

    modport source (output valid, output ch, output last_char, input ready);
    modport sink   (input valid, input ch, input last_char, output ready);
endinterface

FILE: rtl/adf_out_if.sv
// Result channel: valid/ready handshake with one signed fixed-point word.
// No dependencies.
`timescale 1ns / 1ps

interface adf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

FILE: rtl/ascii_decimal_to_fixed.sv
// ASCII decimal string to 16.16 / 24.8 fixed-point parser; uses adf_pkg,
// adf_in_if, adf_out_if and assert_macros.svh.
// Throughput: one character per cycle while i_char.ready is high; the parse state
// updates on each accepted item. The final stage register holds a finished parse
// (ready low) until the shift/add/negate can load it into the output register.
// Reset (i_rst_n low, synchronous): parse state, format and both valid flags clear.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ascii_decimal_to_fixed
    import adf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    adf_in_if.sink    i_char,
    adf_out_if.source o_result
);

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_INT   = 2'd1;
    localparam logic [1:0] PH_FRAC  = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    logic        r_format;
    logic [1:0]  r_phase,      n_phase;
    logic        r_negative,   n_negative;
    logic [31:0] r_int_acc,    n_int_acc;
    logic [16:0] r_frac_acc,   n_frac_acc;
    logic [2:0]  r_frac_count, n_frac_count;

    logic        r_fin_valid;
    logic        r_fin_neg;
    logic        r_fin_fmt;
    logic [31:0] r_fin_int;
    logic [16:0] r_fin_frac;

    logic        r_out_valid;
    logic [31:0] r_out_value;

    logic        in_acc;
    logic        out_can;
    logic        fin_adv;
    logic        is_digit;
    logic [3:0]  digit;
    logic [31:0] shifted;
    logic [31:0] sum;
    logic [31:0] n_value;

    assign out_can = !r_out_valid || o_result.ready;
    assign fin_adv = r_fin_valid && out_can;
    assign i_char.ready = !r_fin_valid || out_can;
    assign in_acc  = i_char.valid && i_char.ready;

    assign is_digit = (i_char.ch >= ADF_CH_ZERO) && (i_char.ch <= ADF_CH_NINE);
    assign digit    = i_char.ch[3:0];

    always_comb begin
        n_phase      = r_phase;
        n_negative   = r_negative;
        n_int_acc    = r_int_acc;
        n_frac_acc   = r_frac_acc;
        n_frac_count = r_frac_count;
        case (r_phase)
            PH_START: begin
                if (i_char.ch == ADF_CH_MINUS) begin
                    n_negative = 1'b1;
                    n_phase    = PH_INT;
                end else if (is_digit) begin
                    n_int_acc = {28'd0, digit};
                    n_phase   = PH_INT;
                end else if (i_char.ch == ADF_CH_PERIOD) begin
                    n_phase = PH_FRAC;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_INT: begin
                if (is_digit) begin
                    // acc * 10 + digit, wrapping at 32 bits
                    n_int_acc = {r_int_acc[28:0], 3'd0} + {r_int_acc[30:0], 1'b0}
                              + {28'd0, digit};
                end else if (i_char.ch == ADF_CH_PERIOD) begin
                    n_phase = PH_FRAC;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_FRAC: begin
                if (is_digit && (r_frac_count < 3'(ADF_MAX_FRAC_DIGITS))) begin
                    n_frac_acc   = r_frac_acc + adf_frac_term(r_format, r_frac_count, digit);
                    n_frac_count = r_frac_count + 3'd1;
                    if (n_frac_count >= 3'(ADF_MAX_FRAC_DIGITS)) begin
                        n_phase = PH_DONE;
                    end
                end else begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= ADF_FMT_16_16;
        end else if (i_cfg_we) begin
            r_format <= i_cfg_wdata;
        end
    end

    // Parse state: restart after the last character of a string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_negative   <= 1'b0;
            r_int_acc    <= '0;
            r_frac_acc   <= '0;
            r_frac_count <= '0;
        end else if (in_acc) begin
            if (i_char.last_char) begin
                r_phase      <= PH_START;
                r_negative   <= 1'b0;
                r_int_acc    <= '0;
                r_frac_acc   <= '0;
                r_frac_count <= '0;
            end else begin
                r_phase      <= n_phase;
                r_negative   <= n_negative;
                r_int_acc    <= n_int_acc;
                r_frac_acc   <= n_frac_acc;
                r_frac_count <= n_frac_count;
            end
        end
    end

    // Final stage: hold the finished parse until the output register frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (in_acc && i_char.last_char) begin
            r_fin_valid <= 1'b1;
        end else if (fin_adv) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_char.last_char) begin
            r_fin_neg  <= n_negative;
            r_fin_fmt  <= r_format;
            r_fin_int  <= n_int_acc;
            r_fin_frac <= n_frac_acc;
        end
    end

    assign shifted = (r_fin_fmt == ADF_FMT_24_8) ? {r_fin_int[23:0], 8'd0}
                                                 : {r_fin_int[15:0], 16'd0};
    assign sum     = shifted + {15'd0, r_fin_frac};
    assign n_value = r_fin_neg ? (32'd0 - sum) : sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_adv) begin
            r_out_value <= n_value;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.value = r_out_value;

    `AST_NEXT(a_last_reaches_fin, i_clk, i_rst_n, in_acc && i_char.last_char, r_fin_valid)
    `AST_NEXT(a_fin_held, i_clk, i_rst_n, r_fin_valid && !fin_adv, r_fin_valid)
    `AST_IMPL(a_frac_count_range, i_clk, i_rst_n, 1'b1,
              r_frac_count <= 3'(ADF_MAX_FRAC_DIGITS))
    `AST_IMPL(a_frac_only_after_period, i_clk, i_rst_n, r_frac_count != 3'd0,
              (r_phase == PH_FRAC) || (r_phase == PH_DONE))
    `AST_IMPL(a_frac_acc_bound, i_clk, i_rst_n, 1'b1, r_frac_acc <= 17'd65532)

endmodule
